/* rtl/rmsn_pkg.sv */
// rmsn_pkg: widths, reset values, register indexes and fixed constants
// for the RMS row normalizer. No dependencies; used by every rtl file.
`default_nettype none

package rmsn_pkg;

  // payload fields
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int OUT_W    = 16;
  localparam int IN_DATA_W  = SAMPLE_W + GAIN_W;
  localparam int OUT_DATA_W = OUT_W;

  // configuration
  localparam int ROW_LEN_W  = 7;
  localparam int EPS_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = EPS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 1'b1;
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST    = 7'd64;
  localparam logic [EPS_W-1:0]     EPS_RST        = 24'd17;

  localparam int MAX_ROW_DEF = 64;

  // arithmetic
  localparam int SQ_W    = 31;   // sample^2, Q7.24, never negative
  localparam int SUM_W   = 38;   // running sum of squares, wraps
  localparam int MEAN_W  = 39;   // mean square plus epsilon
  localparam int ROOT_W  = 20;   // floor sqrt of MEAN_W bits
  localparam int INV_W   = 29;   // inverse root, Q.16
  localparam int DIV_N_W = SUM_W;
  localparam int DIV_D_W = ROOT_W;
  localparam logic [INV_W-1:0]   INV_MAX = {INV_W{1'b1}};
  localparam logic [DIV_N_W-1:0] INV_NUM = 38'd268435456;  // 1.0 as 2^28

endpackage

`default_nettype wire

/* rtl/rmsn_div.sv */
// rmsn_div: restoring divider, one quotient bit per cycle.
// Depends on rmsn_pkg for operand widths. Divisor must be nonzero.
`default_nettype none

module rmsn_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rmsn_pkg::DIV_N_W-1:0] dividend,
  input  wire logic [rmsn_pkg::DIV_D_W-1:0] divisor,
  output logic                             done,
  output logic [rmsn_pkg::DIV_N_W-1:0]      quotient
);
  import rmsn_pkg::*;

  localparam int STEP_W = $clog2(DIV_N_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_N_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [DIV_N_W-1:0]  quo_r;
  logic [DIV_D_W-1:0]  rem_r;
  logic [DIV_D_W-1:0]  dvs_r;

  logic [DIV_D_W:0]    rem_sh;
  logic [DIV_D_W:0]    rem_diff;
  logic                fits;

  assign rem_sh   = {rem_r, quo_r[DIV_N_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs_r};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_N_W-2:0], fits};
      rem_r <= fits ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* rtl/rmsn_sqrt.sv */
// rmsn_sqrt: digit-by-digit floor square root, one root bit per cycle.
// Depends on rmsn_pkg for MEAN_W and ROOT_W.
`default_nettype none

module rmsn_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rmsn_pkg::MEAN_W-1:0] radicand,
  output logic                             done,
  output logic [rmsn_pkg::ROOT_W-1:0]      root
);
  import rmsn_pkg::*;

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;

  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic [REM_W+1:0]    rem_diff;
  logic                fits;

  // bring down two radicand bits, try appending a one to the root
  assign rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign fits     = rem_sh >= trial;
  assign rem_diff = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'(radicand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= fits ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

/* rtl/rms_normalize_row.sv */
// rms_normalize_row: RMS normalization of one row, fixed point.
// Depends on rmsn_pkg, rmsn_div and rmsn_sqrt.
//
//   channel  dir  beat contents
//   in_      in   tdata = sample[15:0], gain[31:16]
//   out_     out  tdata = normalized_value[15:0]; tlast = row_end
//   cfg_     in   index 0 row_length, 1 epsilon; write only
//
// Loading: one beat per cycle into the row memory; each square is registered, then summed.
// After the last beat of a row: the 38-step shared divider gives the mean square, the 20-step
// square root takes its root, the divider the inverse (a zero root saturates it); then
// n reads from the memory port, one per cycle while under 8 results are read and undelivered.
// Reset is synchronous; memory contents are not cleared. out_tready low fills an
// 8-deep result queue, then reads pause; the next row loads while results drain.
`default_nettype none

module rms_normalize_row #(
  parameter int MAX_ROW = rmsn_pkg::MAX_ROW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rmsn_pkg::IN_DATA_W-1:0] in_tdata,   // sample, gain
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [rmsn_pkg::OUT_DATA_W-1:0]     out_tdata,  // normalized_value
  output logic                                out_tlast,  // row_end
  input  wire logic                           cfg_wr_en,
  input  wire logic [rmsn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rmsn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rmsn_pkg::*;

  localparam int ADDR_W   = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int CNT_W    = $clog2(MAX_ROW + 1);
  localparam int Q_DEPTH  = 8;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);
  localparam int MEM_W    = SAMPLE_W + GAIN_W;
  localparam int SG_W     = SAMPLE_W + GAIN_W;
  localparam int PROD_W   = SG_W + INV_W + 1;
  localparam int RND_SH   = 30;
  localparam logic [ROW_LEN_W-1:0] MAX_LEN = ROW_LEN_W'(MAX_ROW);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd536870912);
  localparam logic signed [PROD_W-RND_SH-1:0] SAT_HI = 32'sd32767;
  localparam logic signed [PROD_W-RND_SH-1:0] SAT_LO = -32'sd32768;

  localparam logic [3:0] ST_LOAD    = 4'd0;
  localparam logic [3:0] ST_SUM     = 4'd1;
  localparam logic [3:0] ST_MEAN_GO = 4'd2;
  localparam logic [3:0] ST_MEAN    = 4'd3;
  localparam logic [3:0] ST_ROOT_GO = 4'd4;
  localparam logic [3:0] ST_ROOT    = 4'd5;
  localparam logic [3:0] ST_INV_GO  = 4'd6;
  localparam logic [3:0] ST_INV     = 4'd7;
  localparam logic [3:0] ST_EMIT    = 4'd8;

  // configuration
  logic [ROW_LEN_W-1:0] row_len_r;
  logic [EPS_W-1:0]     eps_r;
  logic [ROW_LEN_W-1:0] eff_len;

  // row control
  logic [3:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    row_n_r;
  logic [CNT_W-1:0]    iss_idx_r;
  logic                in_acc;
  logic                row_done;
  logic [SQ_W-1:0]     sq_r;
  logic                sq_v_r;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [SUM_W-1:0]    sum_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [INV_W-1:0]    inv_r;

  // shared units
  logic                div_start;
  logic [DIV_N_W-1:0]  div_dvd;
  logic [DIV_D_W-1:0]  div_dvs;
  logic                div_done;
  logic [DIV_N_W-1:0]  div_q;
  logic                sqrt_start;
  logic                sqrt_done;
  logic [ROOT_W-1:0]   sqrt_root;

  // row memory and read pipeline
  logic [MEM_W-1:0]    row_mem [MAX_ROW];
  logic [MEM_W-1:0]    rd_data_r;
  logic                issue;
  logic                issue_last;
  logic                p1_v_r, p1_last_r;
  logic                p2_v_r, p2_last_r;
  logic                p3_v_r, p3_last_r;
  logic signed [SG_W-1:0]   sg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-RND_SH-1:0] q_wide;
  logic [OUT_W-1:0]    q_sat;

  // result queue; credits count everything read and not yet delivered
  logic [OUT_W:0]      q_mem [Q_DEPTH];
  logic [Q_AW-1:0]     q_wp_r, q_rp_r;
  logic [Q_CW-1:0]     q_cnt_r;
  logic [Q_CW-1:0]     cred_r;
  logic                out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= ROW_LEN_RST;
      eps_r     <= EPS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROW_LENGTH: row_len_r <= cfg_data[ROW_LEN_W-1:0];
        CFG_EPSILON:    eps_r     <= cfg_data[EPS_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    if (row_len_r == '0) begin
      eff_len = ROW_LEN_W'(1);
    end else if (row_len_r > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = row_len_r;
    end
  end

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign cnt_inc   = cnt_r + 1'b1;
  assign row_done  = ROW_LEN_W'(cnt_inc) >= eff_len;
  assign sq_full   = $signed(in_tdata[SAMPLE_W-1:0]) * $signed(in_tdata[SAMPLE_W-1:0]);

  assign issue      = (state_r == ST_EMIT) && (iss_idx_r != row_n_r) &&
                      (cred_r < Q_CW'(Q_DEPTH));
  assign issue_last = (CNT_W'(iss_idx_r + 1'b1) == row_n_r);

  assign div_start  = (state_r == ST_MEAN_GO) ||
                      ((state_r == ST_INV_GO) && (sqrt_root != '0));
  assign div_dvd    = (state_r == ST_MEAN_GO) ? sum_r : INV_NUM;
  assign div_dvs    = (state_r == ST_MEAN_GO) ? DIV_D_W'(row_n_r) : sqrt_root;
  assign sqrt_start = (state_r == ST_ROOT_GO);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:    if (in_acc && row_done) state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_MEAN_GO;
      ST_MEAN_GO: state_nxt = ST_MEAN;
      ST_MEAN:    if (div_done) state_nxt = ST_ROOT_GO;
      ST_ROOT_GO: state_nxt = ST_ROOT;
      ST_ROOT:    if (sqrt_done) state_nxt = ST_INV_GO;
      ST_INV_GO:  state_nxt = (sqrt_root == '0) ? ST_EMIT : ST_INV;
      ST_INV:     if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:    if (issue && issue_last) state_nxt = ST_LOAD;
      default:    state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      row_n_r   <= '0;
      iss_idx_r <= '0;
      sq_v_r    <= 1'b0;
      sum_r     <= '0;
    end else begin
      state_r <= state_nxt;
      sq_v_r  <= in_acc;
      if (in_acc) begin
        cnt_r <= row_done ? '0 : cnt_inc;
        if (row_done) row_n_r <= cnt_inc;
      end
      // the divider latches the sum on its start cycle
      if (state_r == ST_MEAN_GO) begin
        sum_r     <= '0;
        iss_idx_r <= '0;
      end else if (sq_v_r) begin
        sum_r <= sum_r + SUM_W'(sq_r);
      end
      if (issue) iss_idx_r <= iss_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) sq_r <= sq_full[SQ_W-1:0];
    if ((state_r == ST_MEAN) && div_done) begin
      mean_r <= MEAN_W'(div_q) + MEAN_W'(eps_r);
    end
    if (state_r == ST_INV_GO && sqrt_root == '0) begin
      inv_r <= INV_MAX;
    end else if ((state_r == ST_INV) && div_done) begin
      inv_r <= div_q[INV_W-1:0];
    end
  end

  rmsn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  rmsn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (mean_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // row memory: written while loading, read while emitting, never both
  always_ff @(posedge clk) begin
    if (in_acc) row_mem[cnt_r[ADDR_W-1:0]] <= in_tdata;
    rd_data_r <= row_mem[iss_idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_last_r <= issue_last;
    p2_last_r <= p1_last_r;
    p3_last_r <= p2_last_r;
    sg_r      <= $signed(rd_data_r[SAMPLE_W-1:0]) * $signed(rd_data_r[MEM_W-1:SAMPLE_W]);
    prod_r    <= sg_r * $signed({1'b0, inv_r});
  end

  // round half up, then clamp to 16 bits
  assign rnd    = prod_r + RND_HALF;
  assign q_wide = rnd[PROD_W-1:RND_SH];

  always_comb begin
    if (q_wide > SAT_HI) begin
      q_sat = 16'h7FFF;
    end else if (q_wide < SAT_LO) begin
      q_sat = 16'h8000;
    end else begin
      q_sat = q_wide[OUT_W-1:0];
    end
  end

  assign out_tvalid = (q_cnt_r != '0);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = q_mem[q_rp_r][OUT_W-1:0];
  assign out_tlast  = q_mem[q_rp_r][OUT_W];

  always_ff @(posedge clk) begin
    if (p3_v_r) q_mem[q_wp_r] <= {p3_last_r, q_sat};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
      cred_r  <= '0;
    end else begin
      if (p3_v_r)  q_wp_r <= q_wp_r + 1'b1;
      if (out_acc) q_rp_r <= q_rp_r + 1'b1;
      q_cnt_r <= q_cnt_r + Q_CW'(p3_v_r) - Q_CW'(out_acc);
      cred_r  <= cred_r + Q_CW'(issue) - Q_CW'(out_acc);
    end
  end

  a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= Q_CW'(Q_DEPTH) && q_cnt_r <= cred_r)
    else $error("result credits out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    p3_v_r |-> (q_cnt_r < Q_CW'(Q_DEPTH)) || out_acc)
    else $error("result queue written while full");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_MEAN) || (state_r == ST_INV))
    else $error("divider finished outside a wait state");

  a_read_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !in_acc && (iss_idx_r < row_n_r))
    else $error("row read overlaps loading or runs past the row");

endmodule

`default_nettype wire

/* test/rmsn_checker.sv */
// rmsn_checker: watches the in_, out_ and cfg_ ports of rms_normalize_row,
// predicts every normalized beat in fixed point and compares it with the block.
// Depends on rmsn_pkg for widths, register indexes and reset values.
`timescale 1ns / 100ps

module rmsn_checker #(
  parameter int MAX_ROW = rmsn_pkg::MAX_ROW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rmsn_pkg::IN_DATA_W-1:0]  in_tdata,   // sample, gain
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rmsn_pkg::OUT_DATA_W-1:0] out_tdata,  // normalized_value
  input  logic                            out_tlast,  // row_end
  input  logic                            cfg_wr_en,
  input  logic [rmsn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmsn_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     pending_results,
  output int unsigned                     mismatch_count,
  output int unsigned                     rows_completed
);
  import rmsn_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    row_end;
  } norm_beat_t;

  norm_beat_t expected_beats[$];

  logic [SAMPLE_W-1:0]  sample_mem [MAX_ROW];
  logic [GAIN_W-1:0]    gain_mem   [MAX_ROW];
  logic [SUM_W-1:0]     square_acc;
  int unsigned          fill_count;
  logic [ROW_LEN_W-1:0] row_len_reg;
  logic [EPS_W-1:0]     eps_reg;
  int unsigned          errors;
  int unsigned          rows_done;
  int unsigned          out_beats;

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned rem, res, bitv;
    rem  = v;
    res  = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // zero length acts as one, anything past the buffer depth as the depth
  function automatic int unsigned row_target();
    if (row_len_reg == 0) return 1;
    if (row_len_reg > MAX_ROW) return MAX_ROW;
    return row_len_reg;
  endfunction

  task automatic emit_row_results();
    longint unsigned mean, root, inv;
    longint          s, g, p, q;
    norm_beat_t      beat;
    mean = longint'(square_acc) / fill_count + eps_reg;
    root = floor_root(mean);
    if (root == 0) begin
      inv = INV_MAX;
    end else begin
      inv = (64'd1 << 28) / root;
      if (inv > INV_MAX) inv = INV_MAX;
    end
    for (int k = 0; k < fill_count; k++) begin
      s = $signed(sample_mem[k]);
      g = $signed(gain_mem[k]);
      p = s * g * longint'(inv);
      // round half up, then floor shift
      q = (p + 64'sd536870912) >>> 30;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      beat.value   = q[OUT_W-1:0];
      beat.row_end = (k == fill_count - 1);
      expected_beats.push_back(beat);
    end
    rows_done++;
  endtask

  always @(posedge clk) begin
    norm_beat_t want;
    longint     x;
    if (!rst_n) begin
      expected_beats.delete();
      square_acc  = '0;
      fill_count  = 0;
      row_len_reg = ROW_LEN_RST;
      eps_reg     = EPS_RST;
      errors      = 0;
      rows_done   = 0;
      out_beats   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result beat %0d: value %0d row_end %0b",
                     $time, out_beats, $signed(out_tdata), out_tlast);
        end else begin
          want = expected_beats.pop_front();
          if (out_tdata !== want.value || out_tlast !== want.row_end) begin
            errors++;
            if (errors <= 10)
              $display("[%0t] beat %0d: expected value %0d row_end %0b, got value %0d row_end %0b",
                       $time, out_beats, want.value, want.row_end,
                       $signed(out_tdata), out_tlast);
          end
        end
        out_beats++;
      end

      if (cfg_wr_en) begin
        if (cfg_index == CFG_ROW_LENGTH) row_len_reg = cfg_data[ROW_LEN_W-1:0];
        else if (cfg_index == CFG_EPSILON) eps_reg = cfg_data[EPS_W-1:0];
      end

      if (in_tvalid && in_tready) begin
        x = $signed(in_tdata[SAMPLE_W-1:0]);
        if (fill_count >= MAX_ROW) fill_count = 0;
        sample_mem[fill_count] = in_tdata[SAMPLE_W-1:0];
        gain_mem[fill_count]   = in_tdata[IN_DATA_W-1:SAMPLE_W];
        square_acc = square_acc + x * x;
        fill_count++;
        if (fill_count >= row_target()) begin
          emit_row_results();
          square_acc = '0;
          fill_count = 0;
        end
      end
    end
    pending_results <= expected_beats.size();
    mismatch_count  <= errors;
    rows_completed  <= rows_done;
  end

endmodule

/* test/tb.sv */
// tb: stimulus and verdict for rms_normalize_row; the block sits beside
// rmsn_checker, which predicts and compares. Depends on rmsn_pkg.
`timescale 1ns / 100ps

module tb;
  import rmsn_pkg::*;

  localparam int SETTLE_CYCLES  = 240;   // room for a full row's loading and arithmetic, plus margin
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TOTAL_ITEMS    = 200;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int unsigned pending_results, mismatch_count, rows_completed;
  int unsigned items_sent = 0;
  int unsigned settings   = 0;
  int          burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_cyc   = 0;
  int          stall_mode  = 0;

  rms_normalize_row u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rmsn_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count),
    .rows_completed  (rows_completed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: stall pattern switches at random among four modes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall_cyc++;
      if (stall_cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= (stall_cyc % 5 == 0);
        default: out_tready <= (stall_cyc % 32) >= 20;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                 idle_cycles, pending_results);
        $display("** rms_normalize_row: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [15:0] extreme_value();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [15:0] pick_sample(input int mode);
    case (mode)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 30)) - 16'd15;
      2:       return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0000;
      default: return extreme_value();
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    return ($urandom_range(0, 3) == 0) ? extreme_value() : 16'($urandom);
  endfunction

  task automatic send_item(input logic [15:0] s, input logic [15:0] g);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {g, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // all results out, then let any loading or arithmetic finish
  task automatic settle();
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] len_word,
                           input logic [CFG_DATA_W-1:0] eps_word);
    in_tvalid <= 1'b0;
    burst_left = 0;
    settle();
    write_reg(CFG_ROW_LENGTH, len_word);
    write_reg(CFG_EPSILON, eps_word);
    settings++;
  endtask

  task automatic send_rows(input int len7, input int rows, input bit allow_partial);
    int eff, mode;
    eff = (len7 == 0) ? 1 : (len7 > MAX_ROW_DEF) ? MAX_ROW_DEF : len7;
    for (int r = 0; r < rows; r++) begin
      mode = $urandom_range(0, 3);
      for (int e = 0; e < eff; e++) send_item(pick_sample(mode), pick_gain());
    end
    // leave a row half loaded so the next setting may cut it short
    if (allow_partial && eff > 1 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, eff - 1)) send_item(pick_sample(0), pick_gain());
  endtask

  initial begin
    int len7, rows;
    logic [CFG_DATA_W-1:0] eps_word;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length and epsilon: three beats stay buffered, then shortening the
    // row closes it on the next beat with all four elements
    send_item(16'h7FFF, 16'h4000);
    send_item(16'h8000, 16'hC000);
    send_item(16'h0123, 16'h7FFF);
    in_tvalid <= 1'b0;
    burst_left = 0;
    settle();
    write_reg(CFG_ROW_LENGTH, 24'd2);
    send_item(16'hFFFF, 16'h8000);

    // single-element rows, no epsilon: zero root, full-scale corners
    configure(24'd1, 24'd0);
    send_item(16'h0000, 16'h0000);
    send_item(16'h8000, 16'h8000);
    send_item(16'h7FFF, 16'h7FFF);
    send_item(16'h8000, 16'h7FFF);
    send_item(16'h0001, 16'h7FFF);

    // mean square floors to zero with a nonzero sample: inverse saturates
    configure(24'd2, 24'd0);
    send_item(16'h0001, 16'h7FFF);
    send_item(16'h0000, 16'h8000);

    // length zero behaves as one; largest epsilon
    configure(24'd0, 24'hFFFFFF);
    send_item(16'h3039, 16'hB1E0);

    configure(24'd3, 24'd17);
    send_item(16'h7FFF, 16'h8000);
    send_item(16'h8000, 16'h7FFF);
    send_item(16'hFFFF, 16'h0001);

    // full rows: plain maximum, then a length past the buffer depth
    configure({17'($urandom), 7'd64}, 24'd17);
    send_rows(64, 1, 1'b0);
    configure({17'($urandom), 7'd127}, 24'hFFFFFF);
    send_rows(127, 1, 1'b1);

    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len7 = 0;
        1:       len7 = 1;
        2:       len7 = $urandom_range(13, 40);
        default: len7 = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 3))
        0:       eps_word = 24'd0;
        1:       eps_word = 24'd17;
        2:       eps_word = 24'hFFFFFF;
        default: eps_word = 24'($urandom);
      endcase
      rows = (len7 > 12) ? 1 : $urandom_range(1, 3);
      configure({17'($urandom), 7'(len7)}, eps_word);
      send_rows(len7, rows, 1'b1);
    end

    in_tvalid <= 1'b0;
    settle();
    $display("covered %0d input beats in %0d rows over %0d register settings",
             items_sent, rows_completed, settings);
    $display("row lengths 0 to 127 incl. mid-row shortening, epsilon 0 to full scale");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("** rms_normalize_row: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count, pending_results);
      $display("** rms_normalize_row: FAILED **");
    end
    $finish;
  end

endmodule
